FILE: sv/utad_pkg.sv
// ----------------------------------------------------------------------------
// utad_pkg
// Shared types, constants and the digit character table of the unsigned
// to ASCII digit converter.
// ----------------------------------------------------------------------------
package utad_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RESULTS    = 11;
  localparam int BASE_W         = 2;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int INDEX_W        = 4;
  localparam int LIMIT_W        = 4;
  localparam logic [LIMIT_W-1:0] MAX_CHARS_RST = LIMIT_W'(MAX_RESULTS);

  typedef enum logic [BASE_W-1:0] {
    BASE_DEC  = 2'd0,
    BASE_HEX  = 2'd1,
    BASE_OCT  = 2'd2,
    BASE_NONE = 2'd3
  } base_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the digit shift register.
  typedef struct packed {
    logic load;
    logic step_bit;
    logic step_digit;
  } dp_ctrl_t;

  localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

endpackage

FILE: sv/utad_if.sv
// ----------------------------------------------------------------------------
// utad_if
// Valid/ready channels of the converter: number requests, digit results
// and the max_chars register write.
// ----------------------------------------------------------------------------
interface utad_in_if #(
  parameter int VALUE_BITS = utad_pkg::VALUE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [VALUE_BITS-1:0]         value;
  logic [utad_pkg::BASE_W-1:0]   base_code;

  modport source (output valid, output value, output base_code, input ready);
  modport sink   (input valid, input value, input base_code, output ready);
endinterface

interface utad_out_if;
  logic                          valid;
  logic                          ready;
  logic [utad_pkg::CHAR_W-1:0]   digit_char;
  logic [utad_pkg::INDEX_W-1:0]  char_index;
  logic                          is_last;

  modport source (output valid, output digit_char, output char_index,
                  output is_last, input ready);
  modport sink   (input valid, input digit_char, input char_index,
                  input is_last, output ready);
endinterface

interface utad_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [utad_pkg::LIMIT_W-1:0]  max_chars;

  modport source (output valid, output max_chars, input ready);
  modport sink   (input valid, input max_chars, output ready);
endinterface

FILE: sv/utad_digit_shreg.sv
// ----------------------------------------------------------------------------
// utad_digit_shreg
// Bit-serial conversion datapath: the value shifts out one bit per cycle
// into a chain of 4-bit digit slots, then the digits shift out one slot
// per cycle from the most significant end, unless the result side stalls.
// ----------------------------------------------------------------------------
module utad_digit_shreg #(
  parameter int VALUE_BITS = utad_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  utad_pkg::dp_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0]         value,
  input  logic [utad_pkg::BASE_W-1:0]   base_code,
  output logic [utad_pkg::DIGIT_W-1:0]  top_digit
);

  // Octal needs the most digit slots of the three bases.
  localparam int NDIG = (VALUE_BITS + 2) / 3;

  logic [VALUE_BITS-1:0]                     bits;
  logic [NDIG-1:0][utad_pkg::DIGIT_W-1:0]    digits;
  logic [NDIG-1:0][utad_pkg::DIGIT_W-1:0]    shifted;
  logic [NDIG-1:0][utad_pkg::DIGIT_W-1:0]    adj;
  logic [NDIG-1:0]                           carry;
  logic                                      is_dec;
  logic                                      is_oct;

  // Each slot doubles and takes the carry of the slot below. In decimal a
  // slot of five or more is corrected by three first, so that it carries
  // at ten. Octal slots use only their low three bits.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      logic cin;
      cin = (i == 0) ? bits[VALUE_BITS-1] : carry[(i == 0) ? 0 : i - 1];
      adj[i] = (is_dec && digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
      carry[i] = is_oct ? adj[i][2] : adj[i][3];
      shifted[i] = is_oct ? {1'b0, adj[i][1:0], cin} : {adj[i][2:0], cin};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bits   <= value;
      digits <= '0;
      is_dec <= utad_pkg::base_t'(base_code) == utad_pkg::BASE_DEC;
      is_oct <= utad_pkg::base_t'(base_code) == utad_pkg::BASE_OCT;
    end else if (ctrl.step_bit) begin
      bits   <= {bits[VALUE_BITS-2:0], 1'b0};
      digits <= shifted;
    end else if (ctrl.step_digit) begin
      digits <= {digits[NDIG-2:0], {utad_pkg::DIGIT_W{1'b0}}};
    end
  end

  assign top_digit = digits[NDIG-1];

endmodule

FILE: sv/utad_ctrl.sv
// ----------------------------------------------------------------------------
// utad_ctrl
// Sequencer of the converter: conversion bit count, leading zero skip,
// character emission and the result output register.
// ----------------------------------------------------------------------------
module utad_ctrl #(
  parameter int VALUE_BITS = utad_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [utad_pkg::BASE_W-1:0]   base_code,
  input  logic [utad_pkg::LIMIT_W-1:0]  max_chars,
  input  logic [utad_pkg::DIGIT_W-1:0]  top_digit,
  output utad_pkg::dp_ctrl_t            dp_ctrl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utad_pkg::CHAR_W-1:0]   out_char,
  output logic [utad_pkg::INDEX_W-1:0]  out_index,
  output logic                          out_last
);

  localparam int NDIG  = (VALUE_BITS + 2) / 3;
  localparam int POS_W = $clog2(NDIG);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  utad_pkg::state_t                 state;
  utad_pkg::state_t                 state_next;
  logic [CNT_W-1:0]                 bit_cnt;
  logic [POS_W-1:0]                 pos;
  logic [utad_pkg::INDEX_W-1:0]     k;
  logic [utad_pkg::LIMIT_W-1:0]     limit;
  logic [utad_pkg::LIMIT_W-1:0]     limit_in;
  logic                             go;
  logic                             emit_fire;
  logic                             last;

  assign limit_in = (max_chars > utad_pkg::MAX_CHARS_RST) ? utad_pkg::MAX_CHARS_RST
                                                          : max_chars;
  // A request with the unused base code or a zero limit gives no result.
  assign go = in_valid && (state == utad_pkg::ST_IDLE)
              && (utad_pkg::base_t'(base_code) != utad_pkg::BASE_NONE)
              && (limit_in != '0);
  assign emit_fire = (state == utad_pkg::ST_EMIT) && (!out_valid || out_ready);
  assign last = (pos == '0) || (k == limit - 4'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      utad_pkg::ST_IDLE: begin
        if (go) state_next = utad_pkg::ST_CONV;
      end
      utad_pkg::ST_CONV: begin
        if (bit_cnt == CNT_W'(1)) state_next = utad_pkg::ST_SCAN;
      end
      utad_pkg::ST_SCAN: begin
        if (top_digit != '0 || pos == '0) state_next = utad_pkg::ST_EMIT;
      end
      utad_pkg::ST_EMIT: begin
        if (emit_fire && last) state_next = utad_pkg::ST_IDLE;
      end
      default: state_next = utad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready           = (state == utad_pkg::ST_IDLE);
    dp_ctrl.load       = go;
    dp_ctrl.step_bit   = (state == utad_pkg::ST_CONV);
    dp_ctrl.step_digit = ((state == utad_pkg::ST_SCAN) && top_digit == '0 && pos != '0)
                         || emit_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= utad_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      bit_cnt <= CNT_W'(VALUE_BITS);
      pos     <= POS_W'(NDIG - 1);
      k       <= '0;
      limit   <= limit_in;
    end else begin
      if (state == utad_pkg::ST_CONV) bit_cnt <= bit_cnt - CNT_W'(1);
      if (dp_ctrl.step_digit) pos <= pos - POS_W'(1);
      if (emit_fire) k <= k + 4'd1;
    end
    if (emit_fire) begin
      out_char  <= utad_pkg::DIGIT_TABLE[top_digit];
      out_index <= k;
      out_last  <= last;
    end
  end

endmodule

FILE: sv/unsigned_to_ascii_digits_core.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_core
// Converts an unsigned number to decimal, hexadecimal or octal ASCII digits.
// ----------------------------------------------------------------------------
// Each request carries a number and a base code; the block returns its
// digits most significant first, one result per character, with leading
// zeros dropped, zero given as a single '0', and at most max_chars
// characters (values above 11 act as 11). A request is accepted, then the
// number is shifted bit by bit through the digit chain, then leading zero
// digits are skipped (at most (VALUE_BITS+2)/3 - 1 of them) until the first
// digit is found, and then each character is emitted through the output
// register, which the result side can stall. A new request is taken once
// the last character of the previous one is in the output register. A
// request with base code 3 or a limit of zero is taken and gives no result.
module unsigned_to_ascii_digits_core #(
  parameter int VALUE_BITS = utad_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  utad_in_if.sink    number,
  utad_out_if.source digits,
  utad_cfg_if.sink   cfg
);

  logic [utad_pkg::LIMIT_W-1:0]  max_chars;
  logic [utad_pkg::DIGIT_W-1:0]  top_digit;
  utad_pkg::dp_ctrl_t            dp_ctrl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= utad_pkg::MAX_CHARS_RST;
    end else if (cfg.valid) begin
      max_chars <= cfg.max_chars;
    end
  end

  utad_digit_shreg #(
    .VALUE_BITS (VALUE_BITS)
  ) u_shreg (
    .clk       (clk),
    .ctrl      (dp_ctrl),
    .value     (number.value),
    .base_code (number.base_code),
    .top_digit (top_digit)
  );

  utad_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .base_code (number.base_code),
    .max_chars (max_chars),
    .top_digit (top_digit),
    .dp_ctrl   (dp_ctrl),
    .out_valid (digits.valid),
    .out_ready (digits.ready),
    .out_char  (digits.digit_char),
    .out_index (digits.char_index),
    .out_last  (digits.is_last)
  );

endmodule
